@@ hw/rtl/smx_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package smx_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_GAINS_A = 3'd1;
  localparam logic [2:0] REG_GAINS_B = 3'd2;
  localparam logic [2:0] REG_VTAIL  = 3'd3;
  localparam logic [2:0] REG_DAMP   = 3'd4;

  // mode flag bit positions
  localparam int FLAG_AUTOC    = 0;
  localparam int FLAG_TTRIM    = 1;
  localparam int FLAG_FTRIM    = 2;
  localparam int FLAG_ELEVON   = 3;
  localparam int FLAG_FLAPERON = 4;
  localparam int FLAG_VTAIL    = 5;
  localparam int FLAG_DROLL    = 6;
  localparam int FLAG_DPITCH   = 7;
  localparam int FLAG_DYAW     = 8;
  localparam int FLAG_TUNE     = 9;

  localparam int MODE_W  = 10;
  localparam int FIELD_W = 16;
  // damped channel width: Q1.14 channel plus a damping term of up to 2^21
  localparam int DW      = 23;
  localparam int TUNE_W  = 15;
  localparam int TG_W    = TUNE_W + FIELD_W;
  localparam int RAW_CH  = 8;

  localparam logic signed [TUNE_W-1:0] TUNE_ONE = 15'sd4096;
  localparam logic signed [TUNE_W-1:0] TUNE_TWO = 15'sd8192;
  localparam logic [63:0] DAMP_RESET = 64'h2000_0000_0000_0000;

  // stage advance strobes
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

endpackage
`default_nettype wire

@@ hw/rtl/smx_damp_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
module smx_damp_lane #(
  parameter bit SUB = 1'b0
) (
  input  wire                                       clk,
  input  smx_pkg::pipe_en_t                         en,
  input  wire                                       damp_on,
  input  wire logic signed [smx_pkg::TUNE_W-1:0]    tune,
  input  wire logic signed [smx_pkg::FIELD_W-1:0]   gain,
  input  wire logic signed [smx_pkg::FIELD_W-1:0]   rate,
  input  wire logic signed [smx_pkg::FIELD_W-1:0]   ch_in,
  output logic signed [smx_pkg::DW-1:0]             ch_out
);
  localparam int PRW = smx_pkg::TG_W + smx_pkg::FIELD_W;
  localparam logic signed [PRW-1:0] HALF = PRW'(64'sd2097152);

  logic signed [smx_pkg::TG_W-1:0]    tg_r;
  logic signed [smx_pkg::FIELD_W-1:0] rate_r;
  logic signed [smx_pkg::FIELD_W-1:0] ch2_r;
  logic signed [PRW-1:0]              prod;
  logic signed [PRW-1:0]              prod_rnd;
  logic signed [smx_pkg::DW-1:0]      dterm;
  logic signed [smx_pkg::DW-1:0]      ch_ext;
  logic signed [smx_pkg::DW-1:0]      ch_out_nxt;

  // scale the gain by the tune factor
  always_ff @(posedge clk) begin
    if (en.s2) begin
      tg_r   <= tune * gain;
      rate_r <= rate;
      ch2_r  <= ch_in;
    end
  end

  // apply the rounded damping term
  always_comb begin
    prod     = tg_r * rate_r;
    prod_rnd = prod + HALF;
    dterm    = prod_rnd[22 +: smx_pkg::DW];
    ch_ext   = smx_pkg::DW'(ch2_r);
    if (!damp_on) begin
      ch_out_nxt = ch_ext;
    end else if (SUB) begin
      ch_out_nxt = ch_ext - dterm;
    end else begin
      ch_out_nxt = ch_ext + dterm;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      ch_out <= ch_out_nxt;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/smx_mix_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
module smx_mix_lane #(
  parameter int CHANNELS   = 8,
  parameter int COEF_WIDTH = 16,
  parameter int ROW        = 0
) (
  input  wire                                    clk,
  input  smx_pkg::pipe_en_t                      en,
  input  wire logic signed [COEF_WIDTH-1:0]      coef [CHANNELS],
  input  wire logic signed [smx_pkg::DW-1:0]     ch [CHANNELS],
  input  wire                                    thr_safe,
  output logic signed [smx_pkg::FIELD_W-1:0]     y_r
);
  localparam int PW = COEF_WIDTH + smx_pkg::DW;
  localparam int SW = PW + $clog2(CHANNELS) + 1;
  localparam logic signed [SW-1:0] HALF = SW'(64'sd2048);
  localparam logic signed [SW-1:0] YMAX = SW'(64'sd32767);
  localparam logic signed [SW-1:0] YMIN = SW'(-64'sd32768);

  logic signed [PW-1:0] prod_r [CHANNELS];
  logic                 ts_r;
  logic signed [SW-1:0] acc;
  logic signed [SW-1:0] shifted;
  logic signed [smx_pkg::FIELD_W-1:0] y_nxt;

  // form one product per input channel
  always_ff @(posedge clk) begin
    if (en.s4) begin
      for (int j = 0; j < CHANNELS; j++) begin
        prod_r[j] <= coef[j] * ch[j];
      end
      ts_r <= thr_safe;
    end
  end

  // sum, round to Q1.14 and saturate; row 0 reads zero while throttle-safe is set
  always_comb begin
    acc = '0;
    for (int j = 0; j < CHANNELS; j++) begin
      acc = acc + SW'(prod_r[j]);
    end
    shifted = (acc + HALF) >>> 12;
    if (shifted > YMAX) begin
      y_nxt = 16'sh7fff;
    end else if (shifted < YMIN) begin
      y_nxt = 16'sh8000;
    end else begin
      y_nxt = shifted[smx_pkg::FIELD_W-1:0];
    end
    if (ROW == 0 && ts_r) begin
      y_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      y_r <= y_nxt;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/servo_mixer_with_rate_damping.sv @@
// Throughput: one beat per cycle; five registered stages (tune product, tune*gain,
// damping, matrix products, row sums) each advance whenever the stage after can take.
// Reset (rst_n low, synchronous): pipeline emptied, tune scale field set to 0x2000, mode
// and all gains cleared, so the mixing matrix reads as identity.
`timescale 1ns / 1ps
`default_nettype none
module servo_mixer_with_rate_damping #(
  parameter int CHANNELS   = 8,
  parameter int COEF_WIDTH = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [63:0] in_channels_low,
  input  wire  [63:0] in_channels_high,
  input  wire  signed [15:0] in_roll_rate,
  input  wire  signed [15:0] in_pitch_rate,
  input  wire  signed [15:0] in_yaw_rate,
  input  wire  signed [15:0] in_tune_knob,
  input  wire         in_throttle_safe,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [63:0] out_actuators_low,
  output logic [63:0] out_actuators_high,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [63:0] cfg_data
);
  localparam int FW   = smx_pkg::FIELD_W;
  localparam int DW   = smx_pkg::DW;
  localparam int NOUT = (CHANNELS < smx_pkg::RAW_CH) ? CHANNELS : smx_pkg::RAW_CH;
  localparam logic signed [17:0] Q12_ONE = 18'sd4096;

  logic [smx_pkg::MODE_W-1:0] mode_r;
  logic [63:0] gains_a_r;
  logic [63:0] gains_b_r;
  logic [15:0] vtail_r;
  logic [63:0] damp_r;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  smx_pkg::pipe_en_t en;

  logic signed [FW-1:0] ch1_r [smx_pkg::RAW_CH];
  logic signed [FW-1:0] ch2_r [smx_pkg::RAW_CH];
  logic signed [DW-1:0] ch3_r [smx_pkg::RAW_CH];
  logic signed [DW-1:0] ch_damp [3];
  logic signed [DW-1:0] ch3 [CHANNELS];
  logic signed [FW-1:0] roll1_r, pitch1_r, yaw1_r;
  logic signed [31:0]   p1_r;
  logic                 ts1_r, ts2_r, ts3_r;
  logic signed [smx_pkg::TUNE_W-1:0] tune;
  logic signed [32:0]   p_rnd;
  logic signed [32:0]   p_sh;
  logic signed [COEF_WIDTH-1:0] mat [CHANNELS][CHANNELS];
  logic signed [FW-1:0] y [smx_pkg::RAW_CH];

  function automatic logic signed [COEF_WIDTH-1:0] sat_coef(input logic signed [17:0] v);
    logic signed [17:0] hi;
    logic signed [17:0] lo;
    hi = (COEF_WIDTH >= 18) ? 18'sh1ffff : 18'((64'sd1 <<< (COEF_WIDTH - 1)) - 1);
    lo = (COEF_WIDTH >= 18) ? 18'sh20000 : 18'(-(64'sd1 <<< (COEF_WIDTH - 1)));
    if (v > hi) begin
      sat_coef = COEF_WIDTH'(hi);
    end else if (v < lo) begin
      sat_coef = COEF_WIDTH'(lo);
    end else begin
      sat_coef = COEF_WIDTH'(v);
    end
  endfunction

  function automatic logic signed [17:0] gfield(input logic [63:0] w, input int k);
    gfield = 18'($signed(w[16*k +: 16]));
  endfunction

  // take configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= '0;
      gains_a_r <= '0;
      gains_b_r <= '0;
      vtail_r   <= '0;
      damp_r    <= smx_pkg::DAMP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        smx_pkg::REG_MODE:    mode_r    <= cfg_data[smx_pkg::MODE_W-1:0];
        smx_pkg::REG_GAINS_A: gains_a_r <= cfg_data;
        smx_pkg::REG_GAINS_B: gains_b_r <= cfg_data;
        smx_pkg::REG_VTAIL:   vtail_r   <= cfg_data[15:0];
        smx_pkg::REG_DAMP:    damp_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // build the mixing matrix from mode and gains
  always_comb begin
    logic vt;
    vt = mode_r[smx_pkg::FLAG_VTAIL] && !mode_r[smx_pkg::FLAG_ELEVON];
    for (int r = 0; r < CHANNELS; r++) begin
      for (int c = 0; c < CHANNELS; c++) begin
        mat[r][c] = (r == c) ? sat_coef(Q12_ONE) : '0;
      end
    end
    if (mode_r[smx_pkg::FLAG_AUTOC]) begin
      mat[3][1] = sat_coef(-gfield(gains_a_r, 0));
      if (vt) mat[2][1] = sat_coef(gfield(gains_a_r, 0));
    end
    if (mode_r[smx_pkg::FLAG_TTRIM]) mat[2][0] = sat_coef(gfield(gains_a_r, 1));
    if (mode_r[smx_pkg::FLAG_FTRIM]) begin
      mat[2][4] = sat_coef(gfield(gains_a_r, 2));
      if (vt) mat[3][4] = sat_coef(-gfield(gains_a_r, 2));
    end
    if (mode_r[smx_pkg::FLAG_ELEVON]) begin
      mat[1][1] = sat_coef(gfield(gains_a_r, 3));
      mat[1][2] = sat_coef(gfield(gains_b_r, 0));
      mat[2][1] = sat_coef(gfield(gains_a_r, 3));
      mat[2][2] = sat_coef(-gfield(gains_b_r, 0));
    end else if (mode_r[smx_pkg::FLAG_FLAPERON]) begin
      mat[1][1] = sat_coef(gfield(gains_b_r, 1));
      mat[1][4] = sat_coef(gfield(gains_b_r, 2));
      mat[4][1] = sat_coef(-gfield(gains_b_r, 1));
      mat[4][4] = sat_coef(gfield(gains_b_r, 2));
    end
    if (vt) begin
      mat[2][2] = sat_coef(gfield(gains_b_r, 3));
      mat[2][3] = sat_coef(18'($signed(vtail_r)));
      mat[3][2] = sat_coef(gfield(gains_b_r, 3));
      mat[3][3] = sat_coef(-18'($signed(vtail_r)));
    end
  end

  // advance each stage when the one after can take its beat
  assign rdy5 = !v5_r || !out_stall;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_stall = !rdy1;
  assign en = '{s2: rdy2, s3: rdy3, s4: rdy4, s5: rdy5};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end
  assign out_valid = v5_r;

  // stage 1: unpack channels, form the tune product
  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int j = 0; j < 4; j++) begin
        ch1_r[j]     <= $signed(in_channels_low[16*j +: 16]);
        ch1_r[j + 4] <= $signed(in_channels_high[16*j +: 16]);
      end
      roll1_r  <= in_roll_rate;
      pitch1_r <= in_pitch_rate;
      yaw1_r   <= in_yaw_rate;
      p1_r     <= $signed(damp_r[63:48]) * in_tune_knob;
      ts1_r    <= in_throttle_safe;
    end
  end

  // round and clamp the tune factor to 0..2.0; it is 1.0 while the tune flag is clear
  always_comb begin
    p_rnd = 33'(p1_r) + 33'sd8192;
    p_sh  = p_rnd >>> 14;
    if (!mode_r[smx_pkg::FLAG_TUNE]) begin
      tune = smx_pkg::TUNE_ONE;
    end else if (p1_r < 0) begin
      tune = '0;
    end else if (p_sh > 33'(smx_pkg::TUNE_TWO)) begin
      tune = smx_pkg::TUNE_TWO;
    end else begin
      tune = p_sh[smx_pkg::TUNE_W-1:0];
    end
  end

  smx_damp_lane #(.SUB(1'b1)) u_damp_roll (
    .clk(clk), .en(en), .damp_on(mode_r[smx_pkg::FLAG_DROLL]), .tune(tune),
    .gain($signed(damp_r[15:0])), .rate(roll1_r), .ch_in(ch1_r[1]), .ch_out(ch_damp[0])
  );
  smx_damp_lane #(.SUB(1'b0)) u_damp_pitch (
    .clk(clk), .en(en), .damp_on(mode_r[smx_pkg::FLAG_DPITCH]), .tune(tune),
    .gain($signed(damp_r[31:16])), .rate(pitch1_r), .ch_in(ch1_r[2]), .ch_out(ch_damp[1])
  );
  smx_damp_lane #(.SUB(1'b0)) u_damp_yaw (
    .clk(clk), .en(en), .damp_on(mode_r[smx_pkg::FLAG_DYAW]), .tune(tune),
    .gain($signed(damp_r[47:32])), .rate(yaw1_r), .ch_in(ch1_r[3]), .ch_out(ch_damp[2])
  );

  // delay the undamped channels alongside the damping lanes
  always_ff @(posedge clk) begin
    if (rdy2) begin
      ch2_r <= ch1_r;
      ts2_r <= ts1_r;
    end
    if (rdy3) begin
      for (int j = 0; j < smx_pkg::RAW_CH; j++) begin
        ch3_r[j] <= DW'(ch2_r[j]);
      end
      ts3_r <= ts2_r;
    end
  end

  // channels 1 to 3 come from the damping lanes; channels past the eighth read as zero
  always_comb begin
    for (int j = 0; j < CHANNELS; j++) begin
      if (j >= 1 && j <= 3) begin
        ch3[j] = ch_damp[j - 1];
      end else if (j < smx_pkg::RAW_CH) begin
        ch3[j] = ch3_r[j];
      end else begin
        ch3[j] = '0;
      end
    end
  end

  // one mixing lane per emitted output
  for (genvar r = 0; r < smx_pkg::RAW_CH; r++) begin : g_row
    if (r < NOUT) begin : g_lane
      smx_mix_lane #(.CHANNELS(CHANNELS), .COEF_WIDTH(COEF_WIDTH), .ROW(r)) u_mix (
        .clk(clk), .en(en), .coef(mat[r]), .ch(ch3), .thr_safe(ts3_r), .y_r(y[r])
      );
    end else begin : g_zero
      assign y[r] = '0;
    end
  end

  assign out_actuators_low  = {y[3], y[2], y[1], y[0]};
  assign out_actuators_high = {y[7], y[6], y[5], y[4]};
endmodule
`default_nettype wire

@@ hw/rtl/smx_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module smx_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_stall,
  input wire [63:0] out_actuators_low,
  input wire [63:0] out_actuators_high,
  input wire        cfg_ready
);
  // output is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !$past(rst_n) |-> !out_valid)
    else $error("output beat present after reset");

  // a stalled beat stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled output beat dropped");

  // a stalled beat keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_actuators_low) && $stable(out_actuators_high))
    else $error("stalled output payload changed");

  // configuration is never refused
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port refused a write");
endmodule

bind servo_mixer_with_rate_damping smx_checker u_smx_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_actuators_low(out_actuators_low), .out_actuators_high(out_actuators_high),
  .cfg_ready(cfg_ready)
);
`default_nettype wire
